// ===== hdl/pcc_pkg.sv =====
// ----------------------------------------------------------------------------
// Pauli frame conjugation package
// Command codes, decoded operation codes and phase constants shared by the
// Pauli frame conjugation unit.
// ----------------------------------------------------------------------------
package pcc_pkg;

  localparam int unsigned QubitIndexWidth = 6;
  localparam int unsigned CmdWidth        = 3;
  localparam int unsigned MaskWidth       = 64;
  localparam int unsigned PhaseWidth      = 2;

  typedef enum logic [CmdWidth-1:0] {
    CMD_LOAD  = 3'd0,
    CMD_IDENT = 3'd1,
    CMD_HAD   = 3'd2,
    CMD_SX    = 3'd3,
    CMD_SY    = 3'd4,
    CMD_CZ    = 3'd5,
    CMD_ROT   = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_HAD,
    OP_SX,
    OP_SY,
    OP_CZ
  } op_t;

  typedef struct packed {
    op_t  op;
    logic bad;
  } ctl_t;

  // Adding PHASE_MINUS_I multiplies by -i; xoring PHASE_FLIP negates.
  localparam logic [PhaseWidth-1:0] PHASE_ZERO    = 2'd0;
  localparam logic [PhaseWidth-1:0] PHASE_FLIP    = 2'd2;
  localparam logic [PhaseWidth-1:0] PHASE_MINUS_I = 2'd3;

endpackage

// ===== hdl/pcc_cmd_if.sv =====
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying one gate command per transfer.
// ----------------------------------------------------------------------------
interface pcc_cmd_if
  import pcc_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic [CmdWidth-1:0]        cmd;
  logic [QubitIndexWidth-1:0] qubit_index;
  logic [QubitIndexWidth-1:0] target_index;

  modport source (output valid, output cmd, output qubit_index, output target_index,
                  input ready);
  modport sink (input valid, input cmd, input qubit_index, input target_index,
                output ready);
endinterface

// ===== hdl/pcc_res_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the Pauli operator after each command.
// ----------------------------------------------------------------------------
interface pcc_res_if
  import pcc_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [MaskWidth-1:0]  x_bits;
  logic [MaskWidth-1:0]  z_bits;
  logic [PhaseWidth-1:0] phase_code;
  logic                  bad_command;

  modport source (output valid, output x_bits, output z_bits, output phase_code,
                  output bad_command, input ready);
  modport sink (input valid, input x_bits, input z_bits, input phase_code,
                input bad_command, output ready);
endinterface

// ===== hdl/pcc_decode.sv =====
// ----------------------------------------------------------------------------
// Command decoder
// Turns a registered command into an operation code, a reject flag and
// one-hot selects for the two addressed qubits.
// ----------------------------------------------------------------------------
module pcc_decode
  import pcc_pkg::*;
#(
  parameter int unsigned NUM_QUBITS = 64
) (
  input  logic [CmdWidth-1:0]        cmd,
  input  logic [QubitIndexWidth-1:0] qubit_index,
  input  logic [QubitIndexWidth-1:0] target_index,
  output ctl_t                       ctl,
  output logic [NUM_QUBITS-1:0]      sel_a,
  output logic [NUM_QUBITS-1:0]      sel_b
);

  logic qa_ok;
  logic qb_ok;

  assign qa_ok = {1'b0, qubit_index} < (QubitIndexWidth + 1)'(NUM_QUBITS);
  assign qb_ok = {1'b0, target_index} < (QubitIndexWidth + 1)'(NUM_QUBITS);

  always_comb begin
    for (int i = 0; i < NUM_QUBITS; i++) begin
      sel_a[i] = (qubit_index == QubitIndexWidth'(i));
      sel_b[i] = (target_index == QubitIndexWidth'(i));
    end
  end

  always_comb begin
    ctl.bad = 1'b0;
    ctl.op  = OP_HOLD;
    unique case (cmd_t'(cmd))
      CMD_LOAD: ctl.op = qa_ok ? OP_LOAD : OP_HOLD;
      CMD_IDENT: ctl.op = OP_HOLD;
      CMD_HAD: ctl.op = qa_ok ? OP_HAD : OP_HOLD;
      CMD_SX: ctl.op = qa_ok ? OP_SX : OP_HOLD;
      CMD_SY: ctl.op = qa_ok ? OP_SY : OP_HOLD;
      CMD_CZ: ctl.op = (qa_ok && qb_ok) ? OP_CZ : OP_HOLD;
      default: ctl.bad = 1'b1;
    endcase
  end

endmodule

// ===== hdl/pcc_frame.sv =====
// ----------------------------------------------------------------------------
// Pauli frame register
// Holds the X mask, Z mask and phase, and conjugates them past one gate
// whenever a command advances.
// ----------------------------------------------------------------------------
module pcc_frame
  import pcc_pkg::*;
#(
  parameter int unsigned NUM_QUBITS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  ctl_t                  ctl,
  input  logic [NUM_QUBITS-1:0] sel_a,
  input  logic [NUM_QUBITS-1:0] sel_b,
  output logic [NUM_QUBITS-1:0] x_mask,
  output logic [NUM_QUBITS-1:0] z_mask,
  output logic [PhaseWidth-1:0] phase,
  output logic [NUM_QUBITS-1:0] x_mask_next,
  output logic [NUM_QUBITS-1:0] z_mask_next,
  output logic [PhaseWidth-1:0] phase_next
);

  logic xa;
  logic za;
  logic xb;

  assign xa = |(x_mask & sel_a);
  assign za = |(z_mask & sel_a);
  assign xb = |(x_mask & sel_b);

  always_comb begin
    x_mask_next = x_mask;
    z_mask_next = z_mask;
    phase_next  = phase;
    unique case (ctl.op)
      OP_HOLD: begin
      end
      OP_LOAD: begin
        x_mask_next = '0;
        z_mask_next = sel_a;
        phase_next  = PHASE_ZERO;
      end
      OP_HAD: begin
        x_mask_next = (x_mask & ~sel_a) | (z_mask & sel_a);
        z_mask_next = (z_mask & ~sel_a) | (x_mask & sel_a);
        if (xa && za) begin
          phase_next = phase ^ PHASE_FLIP;
        end
      end
      OP_SX: begin
        if (za) begin
          phase_next  = phase + PHASE_MINUS_I;
          x_mask_next = x_mask ^ sel_a;
        end
      end
      OP_SY: begin
        if (xa ^ za) begin
          if (xa) begin
            phase_next = phase ^ PHASE_FLIP;
          end
          x_mask_next = x_mask ^ sel_a;
          z_mask_next = z_mask ^ sel_a;
        end
      end
      OP_CZ: begin
        z_mask_next = z_mask ^ (xa ? sel_b : '0) ^ (xb ? sel_a : '0);
        if (xa && xb) begin
          phase_next = phase ^ PHASE_FLIP;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_mask <= '0;
      z_mask <= '0;
      phase  <= PHASE_ZERO;
    end else if (advance) begin
      x_mask <= x_mask_next;
      z_mask <= z_mask_next;
      phase  <= phase_next;
    end
  end

endmodule

// ===== hdl/pauli_clifford_conjugation_unit.sv =====
// ----------------------------------------------------------------------------
// Pauli frame Clifford conjugation unit
// Tracks one multi-qubit Pauli operator and conjugates it past a stream of
// Clifford gate commands, returning the operator after every command.
//
//   Channel   Direction  Payload
//   cmds      in         cmd, qubit_index, target_index
//   results   out        x_bits, z_bits, phase_code, bad_command
//
// A command is registered into the command stage on transfer, and its result is
// written into the result stage when the command advances, once any result stall clears.
// One command is taken every cycle while results are not stalled; the operator
// feeds back through the frame register, which sets that rate.
// Reset empties both stages and clears the operator to the identity.
// A stalled result holds the command stage; commands are still taken while
// the command stage is empty.
// ----------------------------------------------------------------------------
module pauli_clifford_conjugation_unit
  import pcc_pkg::*;
#(
  parameter int unsigned NUM_QUBITS = 64
) (
  input logic      clk,
  input logic      rst,
  pcc_cmd_if.sink  cmds,
  pcc_res_if.source results
);

  logic                       cmd_valid;
  logic [CmdWidth-1:0]        cmd_op;
  logic [QubitIndexWidth-1:0] cmd_qa;
  logic [QubitIndexWidth-1:0] cmd_qb;
  logic                       advance;

  ctl_t                  ctl;
  logic [NUM_QUBITS-1:0] sel_a;
  logic [NUM_QUBITS-1:0] sel_b;
  logic [NUM_QUBITS-1:0] x_mask;
  logic [NUM_QUBITS-1:0] z_mask;
  logic [PhaseWidth-1:0] phase;
  logic [NUM_QUBITS-1:0] x_mask_next;
  logic [NUM_QUBITS-1:0] z_mask_next;
  logic [PhaseWidth-1:0] phase_next;

  logic                  res_valid;
  logic [MaskWidth-1:0]  res_x;
  logic [MaskWidth-1:0]  res_z;
  logic [PhaseWidth-1:0] res_phase;
  logic                  res_bad;

  assign advance    = cmd_valid && (!res_valid || results.ready);
  assign cmds.ready = !cmd_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (cmds.ready) begin
      cmd_valid <= cmds.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmds.valid && cmds.ready) begin
      cmd_op <= cmds.cmd;
      cmd_qa <= cmds.qubit_index;
      cmd_qb <= cmds.target_index;
    end
  end

  pcc_decode #(
    .NUM_QUBITS(NUM_QUBITS)
  ) u_decode (
    .cmd         (cmd_op),
    .qubit_index (cmd_qa),
    .target_index(cmd_qb),
    .ctl         (ctl),
    .sel_a       (sel_a),
    .sel_b       (sel_b)
  );

  pcc_frame #(
    .NUM_QUBITS(NUM_QUBITS)
  ) u_frame (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .ctl        (ctl),
    .sel_a      (sel_a),
    .sel_b      (sel_b),
    .x_mask     (x_mask),
    .z_mask     (z_mask),
    .phase      (phase),
    .x_mask_next(x_mask_next),
    .z_mask_next(z_mask_next),
    .phase_next (phase_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_x     <= MaskWidth'(x_mask_next);
      res_z     <= MaskWidth'(z_mask_next);
      res_phase <= phase_next;
      res_bad   <= ctl.bad;
    end
  end

  assign results.valid       = res_valid;
  assign results.x_bits      = res_x;
  assign results.z_bits      = res_z;
  assign results.phase_code  = res_phase;
  assign results.bad_command = res_bad;

  // The result on show always mirrors the operator held in the frame.
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_x == MaskWidth'(x_mask) && res_z == MaskWidth'(z_mask) &&
                   res_phase == phase))
    else $error("result register differs from the operator state");

  // A rejected command leaves the operator untouched.
  assert property (@(posedge clk) disable iff (rst)
    (advance && ctl.bad) |=> ($stable(x_mask) && $stable(z_mask) && $stable(phase)))
    else $error("rejected command changed the operator");

  // A command transfer always fills the command stage.
  assert property (@(posedge clk) disable iff (rst)
    (cmds.valid && cmds.ready) |=> cmd_valid)
    else $error("command transfer lost");

  // The operator only moves when a command advances.
  assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(x_mask) && $stable(z_mask) && $stable(phase)))
    else $error("operator changed without a command");

endmodule

// ===== sim/pauli_clifford_conjugation_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Pauli frame Clifford conjugation unit testbench
// Drives gate commands into the unit, keeps its own copy of the Pauli frame
// to predict the operator after each command, and compares every result
// transfer with the oldest prediction. A directed opening covers the index
// extremes, every command code and the single-qubit CZ case; random gate
// sequences built around a loaded qubit follow, with bursts of idling and
// one long result stall.
// ----------------------------------------------------------------------------
module pauli_clifford_conjugation_unit_tb;
  import pcc_pkg::*;

  localparam int unsigned NUM_QUBITS = 64;
  localparam int unsigned RANDOM_ITEMS = 1130;
  localparam int unsigned QUIET_TAIL = 150;
  localparam int unsigned HOLD_AFTER = 300;
  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [CmdWidth-1:0] CMD_SPARE = 3'd7;

  typedef struct packed {
    logic [CmdWidth-1:0]        cmd;
    logic [QubitIndexWidth-1:0] qa;
    logic [QubitIndexWidth-1:0] qb;
  } gate_cmd_t;

  typedef struct packed {
    logic [MaskWidth-1:0]  x_bits;
    logic [MaskWidth-1:0]  z_bits;
    logic [PhaseWidth-1:0] phase;
    logic                  bad;
  } pauli_frame_t;

  logic clk;
  logic rst;

  pcc_cmd_if cmds ();
  pcc_res_if results ();

  pauli_clifford_conjugation_unit #(
    .NUM_QUBITS(NUM_QUBITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cmds(cmds),
    .results(results)
  );

  gate_cmd_t    gate_queue[$];
  pauli_frame_t frames_due[$];

  logic [MaskWidth-1:0]  frame_x;
  logic [MaskWidth-1:0]  frame_z;
  logic [PhaseWidth-1:0] frame_phase;

  int unsigned planned_cmds;
  int unsigned cmds_accepted;
  int unsigned error_count;
  int unsigned cycle_count;
  logic        cmd_taken;
  logic [QubitIndexWidth-1:0] focus_qubit;

  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned recv_hold;
  bit          hold_done;

  gate_cmd_t    next_cmd;
  gate_cmd_t    seen_cmd;
  pauli_frame_t want;

  function automatic pauli_frame_t conjugate(gate_cmd_t g);
    logic [MaskWidth-1:0] sa;
    logic [MaskWidth-1:0] sb;
    logic                 xa;
    logic                 xb;
    logic                 za;
    bit                   qa_ok;
    bit                   qb_ok;
    pauli_frame_t         r;
    sa = {{(MaskWidth-1){1'b0}}, 1'b1} << g.qa;
    sb = {{(MaskWidth-1){1'b0}}, 1'b1} << g.qb;
    qa_ok = g.qa < NUM_QUBITS;
    qb_ok = g.qb < NUM_QUBITS;
    xa = |(frame_x & sa);
    za = |(frame_z & sa);
    xb = |(frame_x & sb);
    r.bad = 1'b0;
    case (g.cmd)
      CMD_ROT, CMD_SPARE: begin
        r.bad = 1'b1;
      end
      CMD_LOAD: begin
        if (qa_ok) begin
          frame_x = '0;
          frame_z = sa;
          frame_phase = PHASE_ZERO;
        end
      end
      CMD_HAD: begin
        if (qa_ok) begin
          if (xa && za) frame_phase = frame_phase ^ PHASE_FLIP;
          frame_x = (frame_x & ~sa) | (za ? sa : '0);
          frame_z = (frame_z & ~sa) | (xa ? sa : '0);
        end
      end
      CMD_SX: begin
        if (qa_ok && za) begin
          frame_phase = frame_phase + PHASE_MINUS_I;
          frame_x = frame_x ^ sa;
        end
      end
      CMD_SY: begin
        if (qa_ok && (xa != za)) begin
          if (xa) frame_phase = frame_phase ^ PHASE_FLIP;
          frame_x = frame_x ^ sa;
          frame_z = frame_z ^ sa;
        end
      end
      CMD_CZ: begin
        if (qa_ok && qb_ok) begin
          if (xa) frame_z = frame_z ^ sb;
          if (xb) frame_z = frame_z ^ sa;
          if (xa && xb) frame_phase = frame_phase ^ PHASE_FLIP;
        end
      end
      default: begin
      end
    endcase
    r.x_bits = frame_x;
    r.z_bits = frame_z;
    r.phase = frame_phase;
    return r;
  endfunction

  task automatic queue_gate(logic [CmdWidth-1:0] c, int unsigned a, int unsigned b);
    gate_cmd_t g;
    g.cmd = c;
    g.qa = a[QubitIndexWidth-1:0];
    g.qb = b[QubitIndexWidth-1:0];
    gate_queue = {gate_queue, g};
  endtask

  function automatic logic [QubitIndexWidth-1:0] pick_qubit();
    logic [QubitIndexWidth-1:0] q;
    if ($urandom_range(0, 9) < 7) q = QubitIndexWidth'(focus_qubit + $urandom_range(0, 7));
    else q = QubitIndexWidth'($urandom_range(0, 63));
    return q;
  endfunction

  function automatic logic [CmdWidth-1:0] pick_gate();
    int unsigned w;
    logic [CmdWidth-1:0] c;
    w = $urandom_range(0, 99);
    if (w < 25) c = CMD_HAD;
    else if (w < 40) c = CMD_SX;
    else if (w < 55) c = CMD_SY;
    else if (w < 85) c = CMD_CZ;
    else if (w < 90) c = CMD_IDENT;
    else if (w < 93) c = CMD_ROT;
    else if (w < 95) c = CMD_SPARE;
    else c = CMD_LOAD;
    return c;
  endfunction

  function automatic bit idling_allowed();
    return (cmds_accepted + QUIET_TAIL < planned_cmds) && (((cmds_accepted / 80) % 4) != 3);
  endfunction

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cmds.valid = 1'b0;
    cmds.cmd = CMD_LOAD;
    cmds.qubit_index = '0;
    cmds.target_index = '0;
    results.ready = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL pauli_clifford_conjugation_unit");
      $finish;
    end
  end

  // Sender: holds an offered command until its transfer, then idles or offers the next.
  always @(negedge clk) begin
    if (rst) begin
      cmds.valid <= 1'b0;
    end else if (cmds.valid && !cmd_taken) begin
    end else if (send_gap > 0) begin
      send_gap = send_gap - 1;
      cmds.valid <= 1'b0;
    end else if (gate_queue.size() == 0) begin
      cmds.valid <= 1'b0;
    end else if (idling_allowed() && $urandom_range(0, 4) == 0) begin
      send_gap = $urandom_range(1, 9) - 1;
      cmds.valid <= 1'b0;
    end else begin
      next_cmd = gate_queue.pop_front();
      cmds.valid <= 1'b1;
      cmds.cmd <= next_cmd.cmd;
      cmds.qubit_index <= next_cmd.qa;
      cmds.target_index <= next_cmd.qb;
    end
  end

  // Receiver: random stalls, plus one long hold so that the unit backs up.
  always @(negedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
    end else begin
      if (!hold_done && cmds_accepted >= HOLD_AFTER) begin
        hold_done = 1'b1;
        recv_hold = HOLD_CYCLES;
      end
      if (recv_hold > 0) begin
        recv_hold = recv_hold - 1;
        results.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap = recv_gap - 1;
        results.ready <= 1'b0;
      end else if (idling_allowed() && $urandom_range(0, 5) == 0) begin
        recv_gap = $urandom_range(1, 9) - 1;
        results.ready <= 1'b0;
      end else begin
        results.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      cmd_taken <= 1'b0;
      frame_x = '0;
      frame_z = '0;
      frame_phase = PHASE_ZERO;
    end else begin
      cmd_taken <= cmds.valid && cmds.ready;
      if (cmds.valid && cmds.ready) begin
        seen_cmd.cmd = cmds.cmd;
        seen_cmd.qa = cmds.qubit_index;
        seen_cmd.qb = cmds.target_index;
        frames_due = {frames_due, conjugate(seen_cmd)};
        cmds_accepted = cmds_accepted + 1;
      end
      if (results.valid && results.ready) begin
        if (frames_due.size() == 0) begin
          $display("%0t: result transfer with nothing expected: x=%h z=%h phase=%0d bad=%0b",
                   $time, results.x_bits, results.z_bits, results.phase_code,
                   results.bad_command);
          error_count = error_count + 1;
        end else begin
          want = frames_due.pop_front();
          if (results.x_bits !== want.x_bits) begin
            $display("%0t: x_bits expected %h actual %h", $time, want.x_bits, results.x_bits);
            error_count = error_count + 1;
          end
          if (results.z_bits !== want.z_bits) begin
            $display("%0t: z_bits expected %h actual %h", $time, want.z_bits, results.z_bits);
            error_count = error_count + 1;
          end
          if (results.phase_code !== want.phase) begin
            $display("%0t: phase_code expected %0d actual %0d", $time, want.phase,
                     results.phase_code);
            error_count = error_count + 1;
          end
          if (results.bad_command !== want.bad) begin
            $display("%0t: bad_command expected %0b actual %0b", $time, want.bad,
                     results.bad_command);
            error_count = error_count + 1;
          end
        end
      end
    end
  end

  initial begin
    int unsigned run_len;
    int unsigned n;
    focus_qubit = '0;
    queue_gate(CMD_LOAD, 0, 0);
    queue_gate(CMD_SX, 0, 63);
    queue_gate(CMD_HAD, 0, 0);
    queue_gate(CMD_SY, 0, 0);
    queue_gate(CMD_CZ, 0, 63);
    queue_gate(CMD_CZ, 63, 0);
    queue_gate(CMD_CZ, 0, 0);
    queue_gate(CMD_HAD, 63, 0);
    queue_gate(CMD_SY, 63, 63);
    queue_gate(CMD_ROT, 63, 63);
    queue_gate(CMD_SPARE, 42, 21);
    queue_gate(CMD_IDENT, 63, 63);
    queue_gate(CMD_LOAD, 63, 0);
    queue_gate(CMD_HAD, 63, 63);
    queue_gate(CMD_SY, 63, 0);
    queue_gate(CMD_SX, 63, 0);
    queue_gate(CMD_CZ, 63, 63);
    queue_gate(CMD_CZ, 63, 21);
    queue_gate(CMD_SY, 21, 0);
    queue_gate(CMD_SX, 0, 0);
    queue_gate(CMD_HAD, 42, 42);
    queue_gate(CMD_LOAD, 21, 63);
    queue_gate(CMD_ROT, 0, 0);
    queue_gate(CMD_IDENT, 0, 0);
    n = 0;
    while (n < RANDOM_ITEMS) begin
      focus_qubit = QubitIndexWidth'($urandom_range(0, 63));
      if ($urandom_range(0, 9) < 7) begin
        queue_gate(CMD_LOAD, focus_qubit + $urandom_range(0, 7), $urandom_range(0, 63));
        n = n + 1;
      end
      run_len = $urandom_range(10, 40);
      repeat (run_len) begin
        queue_gate(pick_gate(), pick_qubit(), pick_qubit());
        n = n + 1;
      end
    end
    planned_cmds = gate_queue.size();
    wait (rst == 1'b0);
    @(negedge clk);
    while (gate_queue.size() > 0 || cmds.valid || frames_due.size() > 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (error_count == 0) begin
      $display("PASS pauli_clifford_conjugation_unit");
    end else begin
      $display("FAIL pauli_clifford_conjugation_unit");
    end
    $finish;
  end

endmodule
